// ----- hdl/bmss_pkg.sv -----
// Shared types and constants for the block motion search SAD unit.
`timescale 1ns / 1ps

package bmss_pkg;

  localparam int BLK_ROWS      = 8;
  localparam int BLK_ROW_BYTES = 8 * 3;
  localparam int BLK_BYTES     = BLK_ROWS * BLK_ROW_BYTES;
  localparam int SA_W          = 8;
  localparam int COLIDX_W      = 5;
  localparam int COORD_W       = 12;
  localparam int CW            = 15;
  localparam int SAD_W         = 16;
  localparam int SAD_MAX       = BLK_BYTES * 255;

  localparam logic [1:0] CMD_LOAD_SRC = 2'd0;
  localparam logic [1:0] CMD_LOAD_WIN = 2'd1;
  localparam logic [1:0] CMD_START    = 2'd2;

  localparam logic [1:0] REG_SEARCH_BREADTH = 2'd0;
  localparam logic [1:0] REG_FRAME_WIDTH    = 2'd1;
  localparam logic [1:0] REG_FRAME_HEIGHT   = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SAD,
    S_DRAIN,
    S_COMPARE,
    S_NEXT,
    S_FINISH
  } bmss_state_t;

endpackage

// ----- hdl/bmss_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module bmss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- hdl/block_motion_search_sad_unit.sv -----
// Top level of the full-search block matching unit with a SAD cost.
// A load beat writes an in-range byte to its RAM; a start beat checks each candidate
// against the frame, skips one outside it and scores one inside it with 192 byte reads
// through one shared subtract-accumulate unit, then drains, compares and advances.
// Throughput: one start at a time; loads take one beat per cycle while idle; a stalled
// result holds the unit in S_FINISH. Reset initialises control and configuration only.
`timescale 1ns / 1ps

module block_motion_search_sad_unit
  import bmss_pkg::*;
#(
  parameter int MAX_BREADTH   = 32,
  parameter int WIN_ROW_BYTES = 128,
  parameter int WIN_ROWS      = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [12:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          cmd,
  input  logic [11:0]         byte_index,
  input  logic [7:0]          byte_value,
  input  logic [11:0]         block_x,
  input  logic [11:0]         block_y,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [COORD_W-1:0]  best_x,
  output logic [COORD_W-1:0]  best_y,
  output logic [SAD_W-1:0]    best_sad,
  output logic                found
);

  localparam int WIN_BYTES = WIN_ROWS * WIN_ROW_BYTES;
  localparam int WA_W      = $clog2(WIN_BYTES);
  localparam int B_W       = $clog2(MAX_BREADTH + 1);
  localparam int D3_W      = $clog2(3 * MAX_BREADTH);
  localparam int COL_W     = $clog2(3 * MAX_BREADTH + BLK_ROW_BYTES);
  localparam int ROW_W     = $clog2(MAX_BREADTH / 2 + BLK_ROWS);

  logic [5:0]  search_breadth;
  logic [12:0] frame_width;
  logic [12:0] frame_height;

  bmss_state_t state, state_next;

  logic [B_W-1:0]      b_eff, hb_in, qb_in, x_span_in, y_span_in;
  logic [B_W-1:0]      x_span, y_span, dx, dy;
  logic [D3_W-1:0]     dx3;
  logic signed [CW-1:0] cand_x, cand_y, y_start, wlim, hlim;
  logic [COORD_W-1:0]  x0, y0;

  logic [SA_W-1:0]     src_addr;
  logic [COLIDX_W-1:0] col;
  logic [ROW_W-1:0]    win_row;
  logic [COL_W-1:0]    win_col;
  logic [WA_W-1:0]     win_rd_addr;
  logic                in_win;
  logic                p1_valid, p1_inwin;
  logic [7:0]          src_q, win_q, win_byte, abs_diff;
  logic [SAD_W-1:0]    sad_acc, best_r;
  logic                found_r;
  logic [COORD_W-1:0]  bx_r, by_r;

  logic in_accept, start_accept, cand_ok, src_last, dx_last, dy_last;
  logic issue_rd, start_sad, take_best, out_load, advance;
  logic src_wr, win_wr;

  assign in_stall     = (state != S_IDLE);
  assign in_accept    = in_valid && !in_stall;
  assign start_accept = in_accept && (cmd == CMD_START);
  assign src_wr = in_accept && (cmd == CMD_LOAD_SRC) &&
                  (32'(byte_index) < 32'(BLK_BYTES));
  assign win_wr = in_accept && (cmd == CMD_LOAD_WIN) &&
                  (32'(byte_index) < 32'(WIN_BYTES));

  assign b_eff = (32'(search_breadth) > 32'(MAX_BREADTH)) ? B_W'(MAX_BREADTH)
                                                          : B_W'(search_breadth);
  assign hb_in     = b_eff >> 1;
  assign qb_in     = b_eff >> 2;
  assign x_span_in = B_W'(hb_in << 1);
  assign y_span_in = B_W'(qb_in << 1);

  assign wlim = CW'(frame_width) - CW'(8);
  assign hlim = CW'(frame_height) - CW'(8);
  assign cand_ok = !cand_x[CW-1] && !cand_y[CW-1] && (cand_x < wlim) && (cand_y < hlim);
  assign dx_last  = (dx == B_W'(x_span - 1'b1));
  assign dy_last  = (dy == B_W'(y_span - 1'b1));
  assign src_last = (src_addr == SA_W'(BLK_BYTES - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start_accept) begin
          state_next = (x_span_in == '0 || y_span_in == '0) ? S_FINISH : S_CHECK;
        end
      end
      S_CHECK:   state_next = cand_ok ? S_SAD : S_NEXT;
      S_SAD:     state_next = src_last ? S_DRAIN : S_SAD;
      S_DRAIN:   state_next = S_COMPARE;
      S_COMPARE: state_next = S_NEXT;
      S_NEXT:    state_next = (dx_last && dy_last) ? S_FINISH : S_CHECK;
      S_FINISH:  state_next = (!out_valid || !out_stall) ? S_IDLE : S_FINISH;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    issue_rd  = (state == S_SAD);
    start_sad = (state == S_CHECK) && cand_ok;
    take_best = (state == S_COMPARE) && (!found_r || (sad_acc < best_r));
    out_load  = (state == S_FINISH) && (!out_valid || !out_stall);
    advance   = (state == S_NEXT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      search_breadth <= 6'd16;
      frame_width    <= 13'd640;
      frame_height   <= 13'd480;
      out_valid      <= 1'b0;
      p1_valid       <= 1'b0;
      found_r        <= 1'b0;
    end else begin
      state    <= state_next;
      p1_valid <= issue_rd;
      if (cfg_write) begin
        unique case (cfg_index)
          REG_SEARCH_BREADTH: search_breadth <= cfg_data[5:0];
          REG_FRAME_WIDTH:    frame_width    <= cfg_data;
          REG_FRAME_HEIGHT:   frame_height   <= cfg_data;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (start_accept) begin
        found_r <= 1'b0;
      end else if (take_best) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_accept) begin
      x0      <= block_x;
      y0      <= block_y;
      bx_r    <= block_x;
      by_r    <= block_y;
      x_span  <= x_span_in;
      y_span  <= y_span_in;
      cand_x  <= CW'(block_x) - CW'(hb_in);
      cand_y  <= CW'(block_y) - CW'(qb_in);
      y_start <= CW'(block_y) - CW'(qb_in);
      dx      <= '0;
      dy      <= '0;
      dx3     <= '0;
    end else if (advance) begin
      if (dy_last) begin
        dy     <= '0;
        cand_y <= y_start;
        dx     <= dx + 1'b1;
        dx3    <= dx3 + D3_W'(3);
        cand_x <= cand_x + CW'(1);
      end else begin
        dy     <= dy + 1'b1;
        cand_y <= cand_y + CW'(1);
      end
    end
    if (take_best) begin
      best_r <= sad_acc;
      bx_r   <= cand_x[COORD_W-1:0];
      by_r   <= cand_y[COORD_W-1:0];
    end
    if (start_sad) begin
      src_addr <= '0;
      col      <= '0;
      win_row  <= ROW_W'(dy);
      win_col  <= COL_W'(dx3);
      sad_acc  <= '0;
    end else begin
      if (issue_rd) begin
        src_addr <= src_addr + 1'b1;
        if (col == COLIDX_W'(BLK_ROW_BYTES - 1)) begin
          col     <= '0;
          win_row <= win_row + 1'b1;
          win_col <= COL_W'(dx3);
        end else begin
          col     <= col + 1'b1;
          win_col <= win_col + 1'b1;
        end
      end
      if (p1_valid) begin
        sad_acc <= sad_acc + SAD_W'(abs_diff);
      end
    end
    p1_inwin <= in_win;
    if (out_load) begin
      best_x   <= found_r ? bx_r : x0;
      best_y   <= found_r ? by_r : y0;
      best_sad <= found_r ? best_r : '0;
      found    <= found_r;
    end
  end

  assign in_win = (32'(win_row) < 32'(WIN_ROWS)) && (32'(win_col) < 32'(WIN_ROW_BYTES));
  assign win_rd_addr = WA_W'(32'(win_row) * WIN_ROW_BYTES + 32'(win_col));
  assign win_byte = p1_inwin ? win_q : 8'd0;
  assign abs_diff = (src_q > win_byte) ? (src_q - win_byte) : (win_byte - src_q);

  bmss_ram #(
    .WIDTH(8),
    .DEPTH(BLK_BYTES)
  ) u_src_ram (
    .clk    (clk),
    .wr_en  (src_wr),
    .wr_addr(SA_W'(byte_index)),
    .wr_data(byte_value),
    .rd_addr(src_addr),
    .rd_data(src_q)
  );

  bmss_ram #(
    .WIDTH(8),
    .DEPTH(WIN_BYTES)
  ) u_win_ram (
    .clk    (clk),
    .wr_en  (win_wr),
    .wr_addr(WA_W'(byte_index)),
    .wr_data(byte_value),
    .rd_addr(win_rd_addr),
    .rd_data(win_q)
  );

  a_start_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    start_accept |=> state != S_IDLE)
    else $error("Start beat did not launch the search.");

  a_no_found_zero_sad: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> best_sad == '0)
    else $error("Result without a candidate carries a nonzero SAD.");

  a_acc_bounded: assert property (@(posedge clk) disable iff (rst)
    state == S_COMPARE |-> 32'(sad_acc) <= 32'(SAD_MAX))
    else $error("SAD accumulator exceeds the largest possible block cost.");

  a_drained_at_compare: assert property (@(posedge clk) disable iff (rst)
    state == S_COMPARE |-> !p1_valid && !issue_rd)
    else $error("Byte pipeline still busy at compare.");

  a_src_addr_range: assert property (@(posedge clk) disable iff (rst)
    issue_rd |-> 32'(src_addr) < 32'(BLK_BYTES))
    else $error("Source read address past the block.");

endmodule
